@@ design/region_map_insert_merge_defines.svh @@
// ----------------------------------------------------------------------------
// Region map assertion macros
// Shared assertion shorthands, clocked on clk_i and disabled during rst_ni low
// ----------------------------------------------------------------------------
`ifndef REGION_MAP_INSERT_MERGE_DEFINES_SVH
`define REGION_MAP_INSERT_MERGE_DEFINES_SVH

// plain property
`define RMIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RMIM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rmim_pkg.sv @@
// ----------------------------------------------------------------------------
// Region map package
// Widths, codes and command/status types shared by the region map modules
// ----------------------------------------------------------------------------
package rmim_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic [KIND_W-1:0] kind;
  } entry_t;

  // outcome of one adjacent pair check
  typedef enum logic [2:0] {
    RC_NEXT,
    RC_MERGE,
    RC_DROP_LEFT,
    RC_TRIM_LEFT,
    RC_SPLIT,
    RC_DROP_RIGHT,
    RC_TRIM_RIGHT,
    RC_TOUCH
  } rcase_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DECODE,
    OP_PL_INIT,
    OP_PL_RD,
    OP_PL_APPEND,
    OP_PL_CMP,
    OP_DR_RD,
    OP_DR_WR,
    OP_DR_END,
    OP_RS_RD,
    OP_RS_RD2,
    OP_RS_LD,
    OP_RS_SUM,
    OP_RS_EVAL,
    OP_RS_ACT,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PL_CHK,
    ST_PL_RD,
    ST_PL_CMP,
    ST_DR_RD,
    ST_DR_WR,
    ST_RS_RD,
    ST_RS_RD2,
    ST_RS_LD,
    ST_RS_SUM,
    ST_RS_EVAL,
    ST_RS_ACT,
    ST_FINISH
  } ctl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    func_e  func;
    logic   insert_ok;
    logic   idx_ok;
    logic   table_full;
    logic   ptr_at_cnt;
    logic   drop_end;
    logic   pair_end;
    rcase_e rcase;
    logic   trim_zero;
  } dp_status_t;

endpackage

@@ design/rmim_req_if.sv @@
// ----------------------------------------------------------------------------
// Region map request channel
// Valid/ready channel carrying one command beat
// ----------------------------------------------------------------------------
interface rmim_req_if;
  logic                          valid;
  logic                          ready;
  logic [rmim_pkg::FUNC_W-1:0]   func;
  logic [rmim_pkg::ADDR_W-1:0]   region_start;
  logic [rmim_pkg::ADDR_W-1:0]   region_length;
  logic [rmim_pkg::KIND_W-1:0]   region_kind;
  logic [rmim_pkg::IDX_W-1:0]    entry_index;

  modport source (output valid, func, region_start, region_length, region_kind,
                  entry_index, input ready);
  modport sink (input valid, func, region_start, region_length, region_kind,
                entry_index, output ready);
endinterface

@@ design/rmim_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Region map response channel
// Valid/ready channel carrying one result beat
// ----------------------------------------------------------------------------
interface rmim_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rmim_pkg::STATUS_W-1:0] status;
  logic [rmim_pkg::ADDR_W-1:0]   out_start;
  logic [rmim_pkg::ADDR_W-1:0]   out_length;
  logic [rmim_pkg::KIND_W-1:0]   out_kind;
  logic [rmim_pkg::CNT_W-1:0]    entry_total;

  modport source (output valid, status, out_start, out_length, out_kind, entry_total,
                  input ready);
  modport sink (input valid, status, out_start, out_length, out_kind, entry_total,
                output ready);
endinterface

@@ design/rmim_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Region map configuration channel
// Valid/ready write channel for the capacity register
// ----------------------------------------------------------------------------
interface rmim_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rmim_pkg::CNT_W-1:0] map_capacity;

  modport source (output valid, map_capacity, input ready);
  modport sink (input valid, map_capacity, output ready);
endinterface

@@ design/rmim_datapath.sv @@
// ----------------------------------------------------------------------------
// Region map datapath
// Region table memory, walk pointers, pair arithmetic and result register
// ----------------------------------------------------------------------------
module rmim_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmim_pkg::dp_cmd_t             cmd_i,
  output rmim_pkg::dp_status_t          status_o,
  input  logic [rmim_pkg::FUNC_W-1:0]   req_func_i,
  input  logic [rmim_pkg::ADDR_W-1:0]   req_start_i,
  input  logic [rmim_pkg::ADDR_W-1:0]   req_length_i,
  input  logic [rmim_pkg::KIND_W-1:0]   req_kind_i,
  input  logic [rmim_pkg::IDX_W-1:0]    req_index_i,
  input  logic                          cfg_write_i,
  input  logic [rmim_pkg::CNT_W-1:0]    cfg_capacity_i,
  output logic [rmim_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [rmim_pkg::ADDR_W-1:0]   rsp_start_o,
  output logic [rmim_pkg::ADDR_W-1:0]   rsp_length_o,
  output logic [rmim_pkg::KIND_W-1:0]   rsp_kind_o,
  output logic [rmim_pkg::CNT_W-1:0]    rsp_total_o
);

  rmim_pkg::entry_t mem_q [rmim_pkg::DEPTH];
  rmim_pkg::entry_t rd_q;

  logic [rmim_pkg::CNT_W-1:0] cnt_q, cnt_d, cap_q, cap_d;
  logic [rmim_pkg::CNT_W-1:0] ptr_q, ptr_d, idx_q, idx_d;
  rmim_pkg::func_e            func_q, func_d;
  rmim_pkg::status_e          stat_q, stat_d;
  logic [rmim_pkg::IDX_W-1:0] index_q, index_d;
  rmim_pkg::rcase_e           rcase_q, rcase_d;
  logic                       zero_q, zero_d;

  rmim_pkg::entry_t           carry_q, carry_d, lft_q, lft_d, rgt_q, rgt_d;
  logic [rmim_pkg::ADDR_W-1:0] lend_q, lend_d, rend_q, rend_d, sel_q, sel_d;

  logic                       re, we;
  logic [rmim_pkg::IDX_W-1:0] raddr, waddr;
  rmim_pkg::entry_t           wdata;

  logic [rmim_pkg::CNT_W-1:0] ptr_inc, idx_inc, cap_eff;
  logic                       ahead, ov, same, lower, cont_rl, cont_lr;
  logic [rmim_pkg::ADDR_W-1:0] trim_len;

  assign ptr_inc = ptr_q + rmim_pkg::CNT_W'(1);
  assign idx_inc = idx_q + rmim_pkg::CNT_W'(1);
  assign cap_eff = (cap_q > rmim_pkg::CNT_W'(rmim_pkg::DEPTH)) ?
                   rmim_pkg::CNT_W'(rmim_pkg::DEPTH) : cap_q;

  // carry sorts ahead of the entry just read
  assign ahead = (carry_q.start == rd_q.start) ? (carry_q.length < rd_q.length)
                                                : (carry_q.start < rd_q.start);
  assign trim_len = zero_q ? '0 : (rgt_q.start - lft_q.start);

  always_comb begin
    status_o.func       = func_q;
    status_o.insert_ok  = (cap_eff >= rmim_pkg::CNT_W'(2)) &&
                          (cnt_q + rmim_pkg::CNT_W'(2) <= cap_eff);
    status_o.idx_ok     = {1'b0, index_q} < cnt_q;
    status_o.table_full = cnt_q == rmim_pkg::CNT_W'(rmim_pkg::DEPTH);
    status_o.ptr_at_cnt = ptr_q == cnt_q;
    status_o.drop_end   = ptr_inc >= cnt_q;
    status_o.pair_end   = idx_inc >= cnt_q;
    status_o.rcase      = rcase_q;
    status_o.trim_zero  = zero_q;
  end

  // pair classification
  always_comb begin
    ov      = (rgt_q.start < lft_q.start) ? (rend_q > lft_q.start) : (rgt_q.start < lend_q);
    same    = lft_q.kind == rgt_q.kind;
    lower   = lft_q.kind < rgt_q.kind;
    cont_rl = (lft_q.start >= rgt_q.start) && (lend_q <= rend_q);
    cont_lr = (rgt_q.start >= lft_q.start) && (rend_q <= lend_q);
    if (ov && same) begin
      rcase_d = rmim_pkg::RC_MERGE;
    end else if (ov && lower && cont_rl) begin
      rcase_d = rmim_pkg::RC_DROP_LEFT;
    end else if (ov && lower && (lend_q <= rend_q)) begin
      rcase_d = rmim_pkg::RC_TRIM_LEFT;
    end else if (ov && lower) begin
      rcase_d = rmim_pkg::RC_SPLIT;
    end else if (ov && cont_lr) begin
      rcase_d = rmim_pkg::RC_DROP_RIGHT;
    end else if (ov) begin
      rcase_d = rmim_pkg::RC_TRIM_RIGHT;
    end else if ((lend_q == rgt_q.start) && same) begin
      rcase_d = rmim_pkg::RC_TOUCH;
    end else begin
      rcase_d = rmim_pkg::RC_NEXT;
    end
  end

  always_comb begin
    cnt_d   = cnt_q;
    cap_d   = cfg_write_i ? cfg_capacity_i : cap_q;
    ptr_d   = ptr_q;
    idx_d   = idx_q;
    func_d  = func_q;
    stat_d  = stat_q;
    index_d = index_q;
    zero_d  = zero_q;
    carry_d = carry_q;
    lft_d   = lft_q;
    rgt_d   = rgt_q;
    lend_d  = lend_q;
    rend_d  = rend_q;
    sel_d   = sel_q;
    re      = 1'b0;
    raddr   = ptr_q[rmim_pkg::IDX_W-1:0];
    we      = 1'b0;
    waddr   = ptr_q[rmim_pkg::IDX_W-1:0];
    wdata   = carry_q;
    unique case (cmd_i.op)
      rmim_pkg::OP_LATCH: begin
        func_d  = rmim_pkg::func_e'(req_func_i);
        index_d = req_index_i;
        carry_d = '{start: req_start_i, length: req_length_i, kind: req_kind_i};
        ptr_d   = {1'b0, req_index_i};
        idx_d   = '0;
      end
      rmim_pkg::OP_DECODE: begin
        re    = 1'b1;
        raddr = index_q;
        unique case (func_q)
          rmim_pkg::FUNC_INSERT:
            stat_d = status_o.insert_ok ? rmim_pkg::STATUS_OK : rmim_pkg::STATUS_FULL;
          rmim_pkg::FUNC_REMOVE, rmim_pkg::FUNC_READ:
            stat_d = status_o.idx_ok ? rmim_pkg::STATUS_OK : rmim_pkg::STATUS_BAD_INDEX;
          default: stat_d = rmim_pkg::STATUS_OK;
        endcase
      end
      rmim_pkg::OP_PL_INIT: ptr_d = '0;
      rmim_pkg::OP_PL_RD: re = 1'b1;
      rmim_pkg::OP_PL_APPEND: begin
        we    = 1'b1;
        waddr = cnt_q[rmim_pkg::IDX_W-1:0];
        cnt_d = cnt_q + rmim_pkg::CNT_W'(1);
      end
      rmim_pkg::OP_PL_CMP: begin
        if (ahead) begin
          we      = 1'b1;
          carry_d = rd_q;
        end
        ptr_d = ptr_inc;
      end
      rmim_pkg::OP_DR_RD: begin
        re    = 1'b1;
        raddr = ptr_inc[rmim_pkg::IDX_W-1:0];
      end
      rmim_pkg::OP_DR_WR: begin
        we    = 1'b1;
        wdata = rd_q;
        ptr_d = ptr_inc;
      end
      rmim_pkg::OP_DR_END: cnt_d = cnt_q - rmim_pkg::CNT_W'(1);
      rmim_pkg::OP_RS_RD: begin
        re    = 1'b1;
        raddr = idx_q[rmim_pkg::IDX_W-1:0];
      end
      rmim_pkg::OP_RS_RD2: begin
        lft_d = rd_q;
        re    = 1'b1;
        raddr = idx_inc[rmim_pkg::IDX_W-1:0];
      end
      rmim_pkg::OP_RS_LD: rgt_d = rd_q;
      rmim_pkg::OP_RS_SUM: begin
        lend_d = lft_q.start + lft_q.length;
        rend_d = rgt_q.start + rgt_q.length;
      end
      rmim_pkg::OP_RS_EVAL: begin
        zero_d = !(rgt_q.start > lft_q.start);
        sel_d  = ((rcase_d == rmim_pkg::RC_MERGE) && (lend_q > rend_q)) ? lend_q : rend_q;
      end
      rmim_pkg::OP_RS_ACT: begin
        waddr = idx_q[rmim_pkg::IDX_W-1:0];
        case (rcase_q)
          rmim_pkg::RC_MERGE, rmim_pkg::RC_TOUCH: begin
            we    = 1'b1;
            wdata = '{start: lft_q.start, length: sel_q - lft_q.start, kind: lft_q.kind};
            ptr_d = idx_inc;
          end
          rmim_pkg::RC_DROP_LEFT: ptr_d = idx_q;
          rmim_pkg::RC_DROP_RIGHT: ptr_d = idx_inc;
          rmim_pkg::RC_TRIM_LEFT: begin
            we    = 1'b1;
            wdata = '{start: lft_q.start, length: trim_len, kind: lft_q.kind};
            idx_d = idx_inc;
          end
          rmim_pkg::RC_SPLIT: begin
            we      = 1'b1;
            wdata   = '{start: lft_q.start, length: trim_len, kind: lft_q.kind};
            carry_d = '{start: rend_q, length: lend_q - rend_q, kind: lft_q.kind};
            ptr_d   = idx_q;
            idx_d   = idx_q + rmim_pkg::CNT_W'(2);
          end
          rmim_pkg::RC_TRIM_RIGHT: begin
            we    = 1'b1;
            waddr = idx_inc[rmim_pkg::IDX_W-1:0];
            wdata = '{start: lend_q, length: rend_q - lend_q, kind: rgt_q.kind};
            idx_d = idx_inc;
          end
          default: idx_d = idx_inc;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cap_q   <= rmim_pkg::CNT_W'(rmim_pkg::DEPTH);
      ptr_q   <= '0;
      idx_q   <= '0;
      func_q  <= rmim_pkg::FUNC_NOP;
      stat_q  <= rmim_pkg::STATUS_OK;
      index_q <= '0;
      rcase_q <= rmim_pkg::RC_NEXT;
      zero_q  <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      ptr_q   <= ptr_d;
      idx_q   <= idx_d;
      func_q  <= func_d;
      stat_q  <= stat_d;
      index_q <= index_d;
      if (cmd_i.op == rmim_pkg::OP_RS_EVAL) begin
        rcase_q <= rcase_d;
      end
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    lft_q   <= lft_d;
    rgt_q   <= rgt_d;
    lend_q  <= lend_d;
    rend_q  <= rend_d;
    sel_q   <= sel_d;
  end

  // region table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem_q[raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rmim_pkg::OP_FINISH) begin
      rsp_status_o <= stat_q;
      rsp_total_o  <= cnt_q;
      if ((func_q == rmim_pkg::FUNC_READ) && (stat_q == rmim_pkg::STATUS_OK)) begin
        rsp_start_o  <= rd_q.start;
        rsp_length_o <= rd_q.length;
        rsp_kind_o   <= rd_q.kind;
      end else begin
        rsp_start_o  <= '0;
        rsp_length_o <= '0;
        rsp_kind_o   <= '0;
      end
    end
  end

endmodule

@@ design/rmim_ctrl.sv @@
// ----------------------------------------------------------------------------
// Region map controller
// Sequences place, drop and pair-resolve walks and the channel handshakes
// ----------------------------------------------------------------------------
module rmim_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rmim_pkg::dp_cmd_t    cmd_o,
  input  rmim_pkg::dp_status_t status_i
);

  rmim_pkg::ctl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 split_q, split_d;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmim_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      split_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      split_q     <= split_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    split_d     = split_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = rmim_pkg::OP_NONE;
    unique case (state_q)
      rmim_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = rmim_pkg::OP_LATCH;
          state_d  = rmim_pkg::ST_DECODE;
        end
      end
      rmim_pkg::ST_DECODE: begin
        cmd_o.op = rmim_pkg::OP_DECODE;
        split_d  = 1'b0;
        state_d  = rmim_pkg::ST_FINISH;
        if ((status_i.func == rmim_pkg::FUNC_INSERT) && status_i.insert_ok) begin
          state_d = rmim_pkg::ST_PL_CHK;
        end else if ((status_i.func == rmim_pkg::FUNC_REMOVE) && status_i.idx_ok) begin
          state_d = rmim_pkg::ST_DR_RD;
        end
      end
      rmim_pkg::ST_PL_CHK: begin
        split_d = 1'b0;
        if (status_i.table_full) begin
          state_d = rmim_pkg::ST_RS_RD;
        end else begin
          cmd_o.op = rmim_pkg::OP_PL_INIT;
          state_d  = rmim_pkg::ST_PL_RD;
        end
      end
      rmim_pkg::ST_PL_RD: begin
        if (status_i.ptr_at_cnt) begin
          cmd_o.op = rmim_pkg::OP_PL_APPEND;
          state_d  = rmim_pkg::ST_RS_RD;
        end else begin
          cmd_o.op = rmim_pkg::OP_PL_RD;
          state_d  = rmim_pkg::ST_PL_CMP;
        end
      end
      rmim_pkg::ST_PL_CMP: begin
        cmd_o.op = rmim_pkg::OP_PL_CMP;
        state_d  = rmim_pkg::ST_PL_RD;
      end
      rmim_pkg::ST_DR_RD: begin
        if (status_i.drop_end) begin
          cmd_o.op = rmim_pkg::OP_DR_END;
          if (status_i.func == rmim_pkg::FUNC_REMOVE) begin
            state_d = rmim_pkg::ST_FINISH;
          end else if (split_q) begin
            state_d = rmim_pkg::ST_PL_CHK;
          end else begin
            state_d = rmim_pkg::ST_RS_RD;
          end
        end else begin
          cmd_o.op = rmim_pkg::OP_DR_RD;
          state_d  = rmim_pkg::ST_DR_WR;
        end
      end
      rmim_pkg::ST_DR_WR: begin
        cmd_o.op = rmim_pkg::OP_DR_WR;
        state_d  = rmim_pkg::ST_DR_RD;
      end
      rmim_pkg::ST_RS_RD: begin
        if (status_i.pair_end) begin
          state_d = rmim_pkg::ST_FINISH;
        end else begin
          cmd_o.op = rmim_pkg::OP_RS_RD;
          state_d  = rmim_pkg::ST_RS_RD2;
        end
      end
      rmim_pkg::ST_RS_RD2: begin
        cmd_o.op = rmim_pkg::OP_RS_RD2;
        state_d  = rmim_pkg::ST_RS_LD;
      end
      rmim_pkg::ST_RS_LD: begin
        cmd_o.op = rmim_pkg::OP_RS_LD;
        state_d  = rmim_pkg::ST_RS_SUM;
      end
      rmim_pkg::ST_RS_SUM: begin
        cmd_o.op = rmim_pkg::OP_RS_SUM;
        state_d  = rmim_pkg::ST_RS_EVAL;
      end
      rmim_pkg::ST_RS_EVAL: begin
        cmd_o.op = rmim_pkg::OP_RS_EVAL;
        state_d  = rmim_pkg::ST_RS_ACT;
      end
      rmim_pkg::ST_RS_ACT: begin
        cmd_o.op = rmim_pkg::OP_RS_ACT;
        case (status_i.rcase)
          rmim_pkg::RC_MERGE, rmim_pkg::RC_TOUCH, rmim_pkg::RC_DROP_LEFT,
          rmim_pkg::RC_DROP_RIGHT: state_d = rmim_pkg::ST_DR_RD;
          rmim_pkg::RC_SPLIT: begin
            split_d = 1'b1;
            state_d = status_i.trim_zero ? rmim_pkg::ST_DR_RD : rmim_pkg::ST_PL_CHK;
          end
          default: state_d = rmim_pkg::ST_RS_RD;
        endcase
      end
      rmim_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = rmim_pkg::OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = rmim_pkg::ST_IDLE;
        end
      end
      default: state_d = rmim_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ design/region_map_insert_merge.sv @@
// ----------------------------------------------------------------------------
// Region map with insert and merge
// Sorted table of (start, length, kind) regions with overlap resolution
// ----------------------------------------------------------------------------
// One command at a time. A read decodes the index and returns the entry; a remove
// shifts every entry above the index down by one. An insert walks the table once
// to place the region, then checks adjacent pairs, and every merge or drop shifts
// the tail down one entry; a split re-places the cut-off piece with another
// placement walk. The walks are paced by the region table memory, which has one
// write port and one registered read port. A finished result waits in the
// output register while the next command is accepted.
module region_map_insert_merge (
  input logic         clk_i,
  input logic         rst_ni,
  rmim_req_if.sink    req_i,
  rmim_rsp_if.source  rsp_o,
  rmim_cfg_if.sink    cfg_i
);

  rmim_pkg::dp_cmd_t    cmd;
  rmim_pkg::dp_status_t dp_status;

  // capacity register is always writable
  assign cfg_i.ready = 1'b1;

  // sequencer for place, drop and pair walks
  rmim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .status_i    (dp_status)
  );

  // table memory, pair arithmetic and result beat register
  rmim_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .req_func_i     (req_i.func),
    .req_start_i    (req_i.region_start),
    .req_length_i   (req_i.region_length),
    .req_kind_i     (req_i.region_kind),
    .req_index_i    (req_i.entry_index),
    .cfg_write_i    (cfg_i.valid),
    .cfg_capacity_i (cfg_i.map_capacity),
    .rsp_status_o   (rsp_o.status),
    .rsp_start_o    (rsp_o.out_start),
    .rsp_length_o   (rsp_o.out_length),
    .rsp_kind_o     (rsp_o.out_kind),
    .rsp_total_o    (rsp_o.entry_total)
  );

endmodule

@@ design/rmim_checker.sv @@
// ----------------------------------------------------------------------------
// Region map checker
// Port-level assertions bound onto the region map top level
// ----------------------------------------------------------------------------
`include "region_map_insert_merge_defines.svh"

module rmim_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [rmim_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [rmim_pkg::ADDR_W-1:0]   rsp_start_i,
  input logic [rmim_pkg::ADDR_W-1:0]   rsp_length_i,
  input logic [rmim_pkg::KIND_W-1:0]   rsp_kind_i,
  input logic [rmim_pkg::CNT_W-1:0]    rsp_total_i
);

  // commands accepted but not yet answered
  logic [1:0] pend_q, pend_d;

  always_comb begin
    pend_d = pend_q + 2'(req_valid_i && req_ready_i) - 2'(rsp_valid_i && rsp_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `RMIM_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_start_i) && $stable(rsp_length_i) && $stable(rsp_kind_i) && $stable(rsp_total_i), "result beat changed while stalled")
  `RMIM_ASSERT_IMP(a_bad_zero, rsp_valid_i && (rsp_status_i == rmim_pkg::STATUS_BAD_INDEX), (rsp_start_i == '0) && (rsp_length_i == '0) && (rsp_kind_i == '0), "bad index beat has region data")
  `RMIM_ASSERT_IMP(a_no_orphan, rsp_valid_i, pend_q != 2'd0, "result beat without a command")
  `RMIM_ASSERT(a_pend_bound, pend_q != 2'd3, "too many commands in flight")
  `RMIM_ASSERT_IMP(a_total, rsp_valid_i, rsp_total_i <= rmim_pkg::CNT_W'(rmim_pkg::DEPTH), "entry total above table depth")

endmodule

bind region_map_insert_merge rmim_checker u_rmim_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_start_i  (rsp_o.out_start),
  .rsp_length_i (rsp_o.out_length),
  .rsp_kind_i   (rsp_o.out_kind),
  .rsp_total_i  (rsp_o.entry_total)
);
